@@ rtl/core/rmsr_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the reversing motor speed ramp.
// No dependencies.
package rmsr_pkg;

  localparam int TICK_BITS_DEF = 24;
  localparam int STEP_W        = 24;
  localparam int PAUSE_W       = 4;
  localparam int SPEED_W       = 8;
  localparam int ACT_W         = 4;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 24;

  localparam logic [SPEED_W-1:0] SPEED_SLOWEST = 8'd255;
  localparam logic [SPEED_W-1:0] SPEED_MIN_OK  = 8'd11;
  localparam logic [SPEED_W-1:0] SPEED_RST     = 8'd150;

  localparam logic [STEP_W-1:0]  STEP_TICKS_RST = 24'd50000;
  localparam logic [PAUSE_W-1:0] PAUSE_UP_RST   = 4'd10;
  localparam logic [PAUSE_W-1:0] PAUSE_DN_RST   = 4'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_UP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_DN   = 2'd2;

  localparam logic [ACT_W-1:0] ACT_TICK       = 4'd0;
  localparam logic [ACT_W-1:0] ACT_UP         = 4'd1;
  localparam logic [ACT_W-1:0] ACT_DOWN       = 4'd2;
  localparam logic [ACT_W-1:0] ACT_OFF        = 4'd3;
  localparam logic [ACT_W-1:0] ACT_SET_SPEED  = 4'd4;
  localparam logic [ACT_W-1:0] ACT_SOFT_UP    = 4'd5;
  localparam logic [ACT_W-1:0] ACT_SOFT_DOWN  = 4'd6;
  localparam logic [ACT_W-1:0] ACT_SOFT_SPEED = 4'd7;
  localparam logic [ACT_W-1:0] ACT_SOFT_OFF   = 4'd8;

  typedef enum logic [5:0] {
    PH_IDLE      = 6'b000001,
    PH_SPEED     = 6'b000010,
    PH_REV_OUT   = 6'b000100,
    PH_REV_PAUSE = 6'b001000,
    PH_REV_BACK  = 6'b010000,
    PH_SOFT_OFF  = 6'b100000
  } phase_t;

endpackage

@@ rtl/core/reversing_motor_speed_ramp_unit.sv @@
`timescale 1ns / 1ps
// Reversing motor speed ramp: command decode, step timer and ramp sequencer.
// Depends on rmsr_pkg.
// The result beat for an item is registered and appears in the cycle after it is accepted.
// One item per cycle while out_stall is low; the output register frees each cycle it is taken.
// in_stall is high only while a result waits in the output register and out_stall holds.
// Reset (rst_n low, synchronous): motor off, heading down, speed 150, no sequence
// running, output empty, registers step_ticks 50000, pauses 10 up and 1 down.
module reversing_motor_speed_ramp_unit #(
  parameter int TICK_COUNTER_BITS = rmsr_pkg::TICK_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [rmsr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rmsr_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [rmsr_pkg::ACT_W-1:0]          in_action,
  input  logic [rmsr_pkg::SPEED_W-1:0]        in_speed_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_motor_on,
  output logic                                out_direction_up,
  output logic [rmsr_pkg::SPEED_W-1:0]        out_drive_speed,
  output logic                                out_write_strobe,
  output logic                                out_busy_res
);
  import rmsr_pkg::*;

  localparam int CW = (TICK_COUNTER_BITS > STEP_W) ? TICK_COUNTER_BITS : STEP_W;

  logic [STEP_W-1:0]  step_ticks_r;
  logic [PAUSE_W-1:0] pause_up_r;
  logic [PAUSE_W-1:0] pause_dn_r;

  logic                          running_r, running_nxt;
  logic                          heading_up_r, heading_up_nxt;
  logic [SPEED_W-1:0]            speed_r, speed_nxt;
  phase_t                        phase_r, phase_nxt;
  logic [SPEED_W-1:0]            target_r, target_nxt;
  logic [SPEED_W-1:0]            saved_r, saved_nxt;
  logic [TICK_COUNTER_BITS-1:0]  tick_r, tick_nxt;
  logic [PAUSE_W-1:0]            pause_r, pause_nxt;
  logic                          wrote;

  logic                          out_valid_r;
  logic                          out_motor_on_r;
  logic                          out_direction_up_r;
  logic [SPEED_W-1:0]            out_drive_speed_r;
  logic                          out_write_strobe_r;
  logic                          out_busy_r;

  logic                          in_accept;
  logic [TICK_COUNTER_BITS-1:0]  tick_inc;
  logic [STEP_W-1:0]             step_lim;
  logic                          step_due;
  logic                          sv_ok;
  logic                          soft_up;
  logic [SPEED_W-1:0]            spd_step;

  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  assign tick_inc = tick_r + 1'b1;
  assign step_lim = (step_ticks_r == '0) ? STEP_W'(1) : step_ticks_r;
  assign step_due = (CW'(tick_inc) >= CW'(step_lim)) || (&tick_inc);
  assign sv_ok    = in_speed_value >= SPEED_MIN_OK;
  assign soft_up  = (in_action == ACT_SOFT_UP);

  always_comb begin
    running_nxt    = running_r;
    heading_up_nxt = heading_up_r;
    speed_nxt      = speed_r;
    phase_nxt      = phase_r;
    target_nxt     = target_r;
    saved_nxt      = saved_r;
    tick_nxt       = tick_r;
    pause_nxt      = pause_r;
    wrote          = 1'b0;
    spd_step       = speed_r;
    if (phase_r != PH_IDLE) begin
      if (in_action == ACT_TICK) begin
        tick_nxt = tick_inc;
        if (step_due) begin
          tick_nxt = '0;
          case (phase_r)
            PH_SPEED: begin
              if (speed_r < target_r) spd_step = speed_r + 1'b1;
              else if (speed_r > target_r) spd_step = speed_r - 1'b1;
              speed_nxt = spd_step;
              if (spd_step == target_r) phase_nxt = PH_IDLE;
              wrote = 1'b1;
            end
            PH_REV_OUT: begin
              if (speed_r < SPEED_SLOWEST) begin
                speed_nxt = speed_r + 1'b1;
              end else begin
                running_nxt = 1'b0;
                pause_nxt   = heading_up_r ? pause_dn_r : pause_up_r;
                phase_nxt   = PH_REV_PAUSE;
              end
              wrote = 1'b1;
            end
            PH_REV_PAUSE: begin
              if (pause_r > 4'd1) begin
                pause_nxt = pause_r - 1'b1;
              end else begin
                pause_nxt      = '0;
                running_nxt    = 1'b1;
                heading_up_nxt = !heading_up_r;
                speed_nxt      = SPEED_SLOWEST;
                phase_nxt      = (saved_r == SPEED_SLOWEST) ? PH_IDLE : PH_REV_BACK;
                wrote          = 1'b1;
              end
            end
            PH_REV_BACK: begin
              if (speed_r > saved_r) spd_step = speed_r - 1'b1;
              else if (speed_r < saved_r) spd_step = speed_r + 1'b1;
              speed_nxt = spd_step;
              if (spd_step == saved_r) phase_nxt = PH_IDLE;
              wrote = 1'b1;
            end
            PH_SOFT_OFF: begin
              if (speed_r < SPEED_SLOWEST) begin
                speed_nxt = speed_r + 1'b1;
              end else begin
                running_nxt    = 1'b0;
                heading_up_nxt = 1'b0;
                phase_nxt      = PH_IDLE;
              end
              wrote = 1'b1;
            end
            default: begin
              phase_nxt = PH_IDLE;
            end
          endcase
        end
      end
    end else begin
      tick_nxt = '0;
      case (in_action)
        ACT_UP: begin
          heading_up_nxt = 1'b1;
          running_nxt    = 1'b1;
          wrote          = 1'b1;
        end
        ACT_DOWN: begin
          heading_up_nxt = 1'b0;
          running_nxt    = 1'b1;
          wrote          = 1'b1;
        end
        ACT_OFF: begin
          heading_up_nxt = 1'b0;
          running_nxt    = 1'b0;
          wrote          = 1'b1;
        end
        ACT_SET_SPEED: begin
          if (sv_ok) begin
            speed_nxt = in_speed_value;
            wrote     = 1'b1;
          end
        end
        ACT_SOFT_UP, ACT_SOFT_DOWN: begin
          if (!running_r) begin
            target_nxt     = speed_r;
            running_nxt    = 1'b1;
            heading_up_nxt = soft_up;
            speed_nxt      = SPEED_SLOWEST;
            phase_nxt      = (speed_r == SPEED_SLOWEST) ? PH_IDLE : PH_SPEED;
            wrote          = 1'b1;
          end else if (heading_up_r != soft_up) begin
            saved_nxt = speed_r;
            if (speed_r == SPEED_SLOWEST) begin
              running_nxt = 1'b0;
              pause_nxt   = heading_up_r ? pause_dn_r : pause_up_r;
              phase_nxt   = PH_REV_PAUSE;
              wrote       = 1'b1;
            end else begin
              phase_nxt = PH_REV_OUT;
            end
          end
        end
        ACT_SOFT_SPEED: begin
          if (sv_ok) begin
            if (!running_r) begin
              speed_nxt = in_speed_value;
            end else if (in_speed_value != speed_r) begin
              target_nxt = in_speed_value;
              phase_nxt  = PH_SPEED;
            end
          end
        end
        ACT_SOFT_OFF: begin
          if (running_r) begin
            if (speed_r == SPEED_SLOWEST) begin
              running_nxt    = 1'b0;
              heading_up_nxt = 1'b0;
              wrote          = 1'b1;
            end else begin
              phase_nxt = PH_SOFT_OFF;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_ticks_r <= STEP_TICKS_RST;
      pause_up_r   <= PAUSE_UP_RST;
      pause_dn_r   <= PAUSE_DN_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_STEP_TICKS: step_ticks_r <= cfg_wdata[STEP_W-1:0];
        CFG_PAUSE_UP:   pause_up_r   <= cfg_wdata[PAUSE_W-1:0];
        CFG_PAUSE_DN:   pause_dn_r   <= cfg_wdata[PAUSE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r    <= 1'b0;
      heading_up_r <= 1'b0;
      speed_r      <= SPEED_RST;
      phase_r      <= PH_IDLE;
      target_r     <= '0;
      saved_r      <= '0;
      tick_r       <= '0;
      pause_r      <= '0;
    end else if (in_accept) begin
      running_r    <= running_nxt;
      heading_up_r <= heading_up_nxt;
      speed_r      <= speed_nxt;
      phase_r      <= phase_nxt;
      target_r     <= target_nxt;
      saved_r      <= saved_nxt;
      tick_r       <= tick_nxt;
      pause_r      <= pause_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_motor_on_r     <= running_nxt;
      out_direction_up_r <= heading_up_nxt;
      out_drive_speed_r  <= speed_nxt;
      out_write_strobe_r <= wrote;
      out_busy_r         <= (phase_nxt != PH_IDLE);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_motor_on     = out_motor_on_r;
  assign out_direction_up = out_direction_up_r;
  assign out_drive_speed  = out_drive_speed_r;
  assign out_write_strobe = out_write_strobe_r;
  assign out_busy_res     = out_busy_r;

endmodule
